>>> rtl/core/fltm_pkg.sv
package fltm_pkg;

    // fixed field widths
    localparam int ENTRY_W  = 64;
    localparam int BASE_W   = 40;
    localparam int VPN_W    = 36;
    localparam int STATUS_W = 2;
    localparam int ADDED_W  = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SKIPPED    = 2'd3;

    // request opcodes
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

endpackage

>>> rtl/core/fltm_ram.sv
module fltm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/fltm_entry_unit.sv
module fltm_entry_unit
    import fltm_pkg::*;
#(
    parameter int TABLE_PAGES      = 64,
    parameter int PAGE_OFFSET_BITS = 12,
    localparam int PGW = $clog2(TABLE_PAGES)
) (
    input  logic [ENTRY_W-1:0] entry,
    input  logic [BASE_W-1:0]  pool_base,
    output logic               present,
    output logic               hit,
    output logic [PGW-1:0]     page
);

    localparam int FW = ENTRY_W - PAGE_OFFSET_BITS;

    logic [FW-1:0] rel;

    // either flag bit marks the entry present
    assign present = |entry[1:0];

    // pool-relative page, modulo the frame field
    assign rel = entry[ENTRY_W-1:PAGE_OFFSET_BITS] - {{(FW-BASE_W){1'b0}}, pool_base};

    assign hit  = present && (rel < FW'(TABLE_PAGES));
    assign page = rel[PGW-1:0];

endmodule

>>> rtl/core/four_level_page_table_mapper.sv
// sequence: a skipped item goes from acceptance straight to the result load, with no table access;
// a walk does one memory read and one decode per level, then the leaf write and the result load,
// plus a clear sweep of the new page and a link write for each table page it allocates
// throughput: one item at a time, as s_ready is high only in the idle state; the next item is
// taken the cycle after a result is registered, even while that result waits
// reset: the whole table store is cleared with s_ready low
module four_level_page_table_mapper
    import fltm_pkg::*;
#(
    parameter int TABLE_PAGES      = 64,
    parameter int LEVELS           = 4,
    parameter int INDEX_BITS       = 9,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BASE_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [VPN_W-1:0]    s_virt_page,
    input  logic [BASE_W-1:0]   s_phys_frame,
    input  logic                s_last_page,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ADDED_W-1:0]  m_tables_added,
    output logic                m_reload_tables
);

    localparam int PGW     = $clog2(TABLE_PAGES);
    localparam int NFW     = $clog2(TABLE_PAGES + 1);
    localparam int DEPTH   = TABLE_PAGES * (1 << INDEX_BITS);
    localparam int AW      = PGW + INDEX_BITS;
    localparam int SW      = LEVELS * INDEX_BITS;
    localparam int LVW     = $clog2(LEVELS);
    localparam int FW      = ENTRY_W - PAGE_OFFSET_BITS;
    localparam int PAD     = PAGE_OFFSET_BITS - 2;

    localparam logic [2:0] S_INIT_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_READ      = 3'd2;
    localparam logic [2:0] S_WAIT      = 3'd3;
    localparam logic [2:0] S_ALLOC_CLR = 3'd4;
    localparam logic [2:0] S_LINK      = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         clr_idx_reg, clr_idx_next;
    logic [NFW-1:0]        next_free_reg, next_free_next;
    logic                  run_failed_reg, run_failed_next;
    logic [BASE_W-1:0]     pool_base_reg, pool_base_next;
    logic                  opcode_reg, opcode_next;
    logic [BASE_W-1:0]     frame_reg, frame_next;
    logic                  last_reg, last_next;
    logic [SW-1:0]         slices_reg, slices_next;
    logic [PGW-1:0]        page_reg, page_next;
    logic [LVW-1:0]        lvl_reg, lvl_next;
    logic [ADDED_W-1:0]    added_reg, added_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [ADDED_W-1:0]    m_added_reg, m_added_next;
    logic                  m_reload_reg, m_reload_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [AW-1:0]         rd_addr;
    logic [ENTRY_W-1:0]    ram_q;
    logic                  ent_present;
    logic                  ent_hit;
    logic [PGW-1:0]        ent_page;
    logic [INDEX_BITS-1:0] cur_slice;
    logic [ENTRY_W-1:0]    vp_ext;
    logic [BASE_W:0]       link_frame;
    logic [ENTRY_W-1:0]    link_entry;
    logic [ENTRY_W-1:0]    leaf_entry;
    logic [PGW-1:0]        free_page;

    // table store
    fltm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // shared entry decode unit
    fltm_entry_unit #(
        .TABLE_PAGES      (TABLE_PAGES),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_entry (
        .entry     (ram_q),
        .pool_base (pool_base_reg),
        .present   (ent_present),
        .hit       (ent_hit),
        .page      (ent_page)
    );

    assign cur_slice  = slices_reg[SW-1 -: INDEX_BITS];
    assign rd_addr    = {page_reg, cur_slice};
    assign vp_ext     = ENTRY_W'(s_virt_page);
    assign free_page  = next_free_reg[PGW-1:0];
    assign link_frame = (BASE_W+1)'(pool_base_reg) + (BASE_W+1)'(next_free_reg);
    assign link_entry = {FW'(link_frame), {PAD{1'b0}}, 2'b11};
    assign leaf_entry = {FW'(frame_reg), {PAD{1'b0}}, 2'b11};

    // handshakes
    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_tables_added  = m_added_reg;
    assign m_reload_tables = m_reload_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        next_free_next  = next_free_reg;
        run_failed_next = run_failed_reg;
        pool_base_next  = pool_base_reg;
        opcode_next     = opcode_reg;
        frame_next      = frame_reg;
        last_next       = last_reg;
        slices_next     = slices_reg;
        page_next       = page_reg;
        lvl_next        = lvl_reg;
        added_next      = added_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_added_next    = m_added_reg;
        m_reload_next   = m_reload_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_addr;
        wr_data         = '0;

        // register write
        if (cfg_valid) begin
            pool_base_next = cfg_data;
        end

        case (state_reg)
            S_INIT_CLR: begin
                // sweep the whole store after reset
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(DEPTH - 1)) begin
                    clr_idx_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    opcode_next = s_opcode;
                    frame_next  = s_phys_frame;
                    last_next   = s_last_page;
                    slices_next = vp_ext[SW-1:0];
                    page_next   = '0;
                    lvl_next    = LVW'(LEVELS - 1);
                    added_next  = '0;
                    if (run_failed_reg) begin
                        status_next = ST_SKIPPED;
                        state_next  = S_DONE;
                    end else begin
                        status_next = ST_DONE;
                        state_next  = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (lvl_reg != '0) begin
                    // intermediate level
                    if (ent_hit) begin
                        page_next   = ent_page;
                        slices_next = slices_reg << INDEX_BITS;
                        lvl_next    = lvl_reg - 1'b1;
                        state_next  = S_READ;
                    end else if (opcode_reg == OP_UNMAP) begin
                        status_next = ST_MISSING;
                        state_next  = S_DONE;
                    end else if (next_free_reg == NFW'(TABLE_PAGES)) begin
                        status_next = ST_POOL_EMPTY;
                        state_next  = S_DONE;
                    end else begin
                        clr_idx_next = '0;
                        state_next   = S_ALLOC_CLR;
                    end
                end else begin
                    // leaf entry
                    if (opcode_reg == OP_MAP) begin
                        wr_en   = 1'b1;
                        wr_data = leaf_entry;
                    end else if (!ent_present) begin
                        status_next = ST_MISSING;
                    end else begin
                        wr_en = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_ALLOC_CLR: begin
                wr_en        = 1'b1;
                wr_addr      = {free_page, clr_idx_reg[INDEX_BITS-1:0]};
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg[INDEX_BITS-1:0]) begin
                    state_next = S_LINK;
                end
            end
            S_LINK: begin
                wr_en          = 1'b1;
                wr_data        = link_entry;
                page_next      = free_page;
                next_free_next = next_free_reg + 1'b1;
                if (added_reg != '1) begin
                    added_next = added_reg + 1'b1;
                end
                slices_next = slices_reg << INDEX_BITS;
                lvl_next    = lvl_reg - 1'b1;
                state_next  = S_READ;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_added_next  = (status_reg == ST_SKIPPED) ? '0 : added_reg;
                    m_reload_next = last_reg && (status_reg == ST_DONE);
                    if (status_reg != ST_DONE) begin
                        run_failed_next = 1'b1;
                    end
                    if (last_reg) begin
                        run_failed_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT_CLR;
            clr_idx_reg    <= '0;
            next_free_reg  <= NFW'(1);
            run_failed_reg <= 1'b0;
            pool_base_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            next_free_reg  <= next_free_next;
            run_failed_reg <= run_failed_next;
            pool_base_reg  <= pool_base_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        opcode_reg   <= opcode_next;
        frame_reg    <= frame_next;
        last_reg     <= last_next;
        slices_reg   <= slices_next;
        page_reg     <= page_next;
        lvl_reg      <= lvl_next;
        added_reg    <= added_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_added_reg  <= m_added_next;
        m_reload_reg <= m_reload_next;
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fltm_pkg::*;

    localparam int TBL_PAGES   = 64;
    localparam int TBL_LEVELS  = 4;
    localparam int INDEX_W     = 9;
    localparam int OFFSET_W    = 12;
    localparam int PAGE_W      = $clog2(TBL_PAGES);
    localparam int FRAME_W     = ENTRY_W - OFFSET_W;
    localparam int STORE_DEPTH = TBL_PAGES << INDEX_W;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic               opcode;
        logic [VPN_W-1:0]   virt_page;
        logic [BASE_W-1:0]  phys_frame;
        logic               last_page;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDED_W-1:0]  tables_added;
        logic                reload_tables;
    } outcome_t;

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [BASE_W-1:0]   cfg_data        = '0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic                s_opcode        = OP_MAP;
    logic [VPN_W-1:0]    s_virt_page     = '0;
    logic [BASE_W-1:0]   s_phys_frame    = '0;
    logic                s_last_page     = 1'b0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ADDED_W-1:0]  m_tables_added;
    logic                m_reload_tables;

    // predicted table state
    logic [ENTRY_W-1:0] page_store [0:STORE_DEPTH-1];
    int                 tables_used = 1;
    bit                 run_broken  = 1'b0;
    logic [BASE_W-1:0]  pool_base   = '0;

    // pending stimulus and expected outcomes
    request_t page_requests [$];
    outcome_t expected_outcomes [$];
    request_t on_bus;
    outcome_t oldest;
    int       requests_queued = 0;
    int       results_seen    = 0;
    int       faults          = 0;
    int       stalled         = 0;

    int send_pause = 0;
    int send_calm  = 0;
    int recv_pause = 0;
    int recv_calm  = 0;

    four_level_page_table_mapper #(
        .TABLE_PAGES      (TBL_PAGES),
        .LEVELS           (TBL_LEVELS),
        .INDEX_BITS       (INDEX_W),
        .PAGE_OFFSET_BITS (OFFSET_W)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_virt_page     (s_virt_page),
        .s_phys_frame    (s_phys_frame),
        .s_last_page     (s_last_page),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_tables_added  (m_tables_added),
        .m_reload_tables (m_reload_tables)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // table index for one level of the walk
    function automatic logic [INDEX_W-1:0] slice_at(input logic [VPN_W-1:0] vp, input int lvl);
        return INDEX_W'(vp >> ((lvl - 1) * INDEX_W));
    endfunction

    function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame);
        return {frame, {(OFFSET_W - 2){1'b0}}, 2'b11};
    endfunction

    // link to a pool page; missing when no flag is set or the frame is outside the pool
    function automatic bit resolve_link(input logic [ENTRY_W-1:0] e,
                                        output logic [PAGE_W-1:0] pg);
        logic [FRAME_W-1:0] rel;
        pg  = '0;
        rel = e[ENTRY_W-1:OFFSET_W] - FRAME_W'(pool_base);
        if (e[1:0] == 2'b00 || rel >= FRAME_W'(TBL_PAGES))
            return 1'b0;
        pg = PAGE_W'(rel);
        return 1'b1;
    endfunction

    // walk the tables for one request and update the predicted state
    function automatic outcome_t walk_tables(input request_t rq);
        outcome_t                    res;
        logic [PAGE_W-1:0]           page;
        logic [PAGE_W-1:0]           nxt;
        logic [PAGE_W+INDEX_W-1:0]   addr;
        int                          added;
        int                          lvl;
        int                          i;
        res.status = ST_DONE;
        page       = '0;
        nxt        = '0;
        added      = 0;
        if (run_broken) begin
            res.status = ST_SKIPPED;
        end else begin
            for (lvl = TBL_LEVELS; lvl >= 2 && res.status == ST_DONE; lvl--) begin
                addr = {page, slice_at(rq.virt_page, lvl)};
                if (!resolve_link(page_store[addr], nxt)) begin
                    if (rq.opcode == OP_UNMAP) begin
                        res.status = ST_MISSING;
                    end else if (tables_used >= TBL_PAGES) begin
                        res.status = ST_POOL_EMPTY;
                    end else begin
                        nxt = PAGE_W'(tables_used);
                        tables_used++;
                        for (i = 0; i < (1 << INDEX_W); i++)
                            page_store[{nxt, INDEX_W'(i)}] = '0;
                        page_store[addr] = make_entry(FRAME_W'(pool_base) + FRAME_W'(nxt));
                        added++;
                    end
                end
                page = nxt;
            end
            // leaf entry
            if (res.status == ST_DONE) begin
                addr = {page, slice_at(rq.virt_page, 1)};
                if (rq.opcode == OP_MAP)
                    page_store[addr] = make_entry(FRAME_W'(rq.phys_frame));
                else if (page_store[addr][1:0] == 2'b00)
                    res.status = ST_MISSING;
                else
                    page_store[addr] = '0;
            end
        end
        if (res.status != ST_DONE)
            run_broken = 1'b1;
        res.reload_tables = rq.last_page && res.status == ST_DONE;
        if (rq.last_page)
            run_broken = 1'b0;
        res.tables_added = (added > 3) ? ADDED_W'(3) : ADDED_W'(added);
        return res;
    endfunction

    // per-item wait, with occasional runs of back-to-back items
    function automatic int pick_pause(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm_left = $urandom_range(5, 25);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endfunction

    task automatic queue_request(input logic op, input logic [VPN_W-1:0] vp,
                                 input logic [BASE_W-1:0] frame, input logic last);
        request_t rq;
        rq.opcode     = op;
        rq.virt_page  = vp;
        rq.phys_frame = frame;
        rq.last_page  = last;
        page_requests.push_back(rq);
        requests_queued++;
    endtask

    // mostly map and unmap within a few regions, plus stray requests anywhere
    task automatic queue_random_phase(input int count, input int stray_pct);
        logic [INDEX_W-1:0]          tops [2];
        logic [VPN_W-INDEX_W-1:0]    regions [4];
        logic [VPN_W-1:0]            recent [$];
        logic [VPN_W-1:0]            vp;
        logic [BASE_W-1:0]           frame;
        logic                        last;
        int                          roll;
        int                          n;
        tops[0] = INDEX_W'($urandom);
        tops[1] = INDEX_W'($urandom);
        for (n = 0; n < 4; n++)
            regions[n] = {tops[$urandom_range(0, 1)], (2 * INDEX_W)'($urandom)};
        // revisit page zero: its upper links may now point outside the pool
        queue_request(OP_UNMAP, '0, '0, 1'b1);
        queue_request(OP_MAP, '0, {8'($urandom), $urandom}, 1'b1);
        for (n = 0; n < count; n++) begin
            roll  = $urandom_range(0, 99);
            frame = {8'($urandom), $urandom};
            last  = ($urandom_range(0, 3) == 0);
            if (roll < stray_pct) begin
                queue_request(1'($urandom), {4'($urandom), $urandom}, frame, last);
            end else if (roll < stray_pct + 30 && recent.size() > 0) begin
                queue_request(OP_UNMAP, recent[$urandom_range(0, recent.size() - 1)],
                              frame, last);
            end else begin
                vp = {regions[$urandom_range(0, 3)], INDEX_W'($urandom)};
                if (roll % 7 == 0) begin
                    queue_request(OP_UNMAP, vp, frame, last);
                end else begin
                    queue_request(OP_MAP, vp, frame, last);
                    recent.push_back(vp);
                    if (recent.size() > 16)
                        void'(recent.pop_front());
                end
            end
        end
    endtask

    task automatic write_pool_base(input logic [BASE_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        pool_base = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_seen < requests_queued)
            @(posedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_outcomes.push_back(walk_tables(on_bus));
            if (!s_valid || s_ready) begin
                if (send_pause > 0) begin
                    send_pause--;
                    s_valid <= 1'b0;
                end else if (page_requests.size() > 0) begin
                    on_bus       = page_requests.pop_front();
                    s_valid      <= 1'b1;
                    s_opcode     <= on_bus.opcode;
                    s_virt_page  <= on_bus.virt_page;
                    s_phys_frame <= on_bus.phys_frame;
                    s_last_page  <= on_bus.last_page;
                    send_pause   = pick_pause(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_outcomes.size() == 0) begin
                    $error("result item with no request outstanding: status %0d", m_status);
                    faults++;
                end else begin
                    oldest = expected_outcomes.pop_front();
                    check_field("status", 4'(oldest.status), 4'(m_status));
                    check_field("tables_added", 4'(oldest.tables_added), 4'(m_tables_added));
                    check_field("reload_tables", 4'(oldest.reload_tables),
                                4'(m_reload_tables));
                end
                recv_pause = pick_pause(recv_calm);
            end
            if (recv_pause > 0) begin
                recv_pause--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stalled <= 0;
        end else if (stalled >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stalled <= stalled + 1;
        end
    end

    // reset, stimulus phases and final verdict
    initial begin
        foreach (page_store[i])
            page_store[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        write_pool_base('0);
        // directed: empty walk, fresh paths, overwrite, stale leaf, skipped runs
        queue_request(OP_UNMAP, '0, '0, 1'b1);
        queue_request(OP_MAP, '0, '0, 1'b0);
        queue_request(OP_MAP, {VPN_W{1'b1}}, {BASE_W{1'b1}}, 1'b0);
        queue_request(OP_MAP, 36'h1, 40'h1, 1'b1);
        queue_request(OP_MAP, '0, 40'hAA_AAAA_AAAA, 1'b1);
        queue_request(OP_UNMAP, '0, 40'h55_5555_5555, 1'b0);
        queue_request(OP_UNMAP, '0, '0, 1'b0);
        queue_request(OP_MAP, 36'h2, 40'h2, 1'b0);
        queue_request(OP_MAP, 36'h3, 40'h3, 1'b1);
        queue_request(OP_UNMAP, 36'h1, '0, 1'b1);
        queue_request(OP_UNMAP, 36'h200, '0, 1'b1);
        queue_request(OP_MAP, 36'h200, 40'h12_3456_789A, 1'b0);
        queue_request(OP_MAP, 36'h4_0000, 40'hFE_DCBA_9876, 1'b0);
        queue_request(OP_MAP, 36'h5_5555_5555, 40'h55_5555_5555, 1'b0);
        queue_request(OP_MAP, 36'hA_AAAA_AAAA, 40'hAA_AAAA_AAAA, 1'b1);
        queue_request(OP_UNMAP, {VPN_W{1'b1}}, {BASE_W{1'b1}}, 1'b1);
        wait_drained();

        // all links made so far fall outside the moved pool
        write_pool_base({BASE_W{1'b1}});
        queue_random_phase(125, 5);
        wait_drained();

        write_pool_base({8'($urandom), $urandom});
        queue_random_phase(125, 5);
        wait_drained();

        // back to base zero; strays use up the rest of the pool
        write_pool_base('0);
        queue_random_phase(125, 25);
        wait_drained();

        repeat (40) @(posedge aclk);
        if (expected_outcomes.size() != 0) begin
            $error("%0d expected result items never arrived", expected_outcomes.size());
            faults++;
        end
        if (faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
